FILE: design/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types and codes for the eight-bit accumulator ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

	localparam int DataW = 8;
	localparam int CmdW  = 5;

	// status byte bit positions
	localparam int FlagS  = 7;
	localparam int FlagZ  = 6;
	localparam int FlagAc = 4;
	localparam int FlagP  = 2;
	localparam int FlagCy = 0;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD = 5'd0,
		CMD_ADC = 5'd1,
		CMD_SUB = 5'd2,
		CMD_SBB = 5'd3,
		CMD_ANA = 5'd4,
		CMD_XRA = 5'd5,
		CMD_ORA = 5'd6,
		CMD_CMP = 5'd7,
		CMD_INR = 5'd8,
		CMD_DCR = 5'd9,
		CMD_DAA = 5'd10,
		CMD_RLC = 5'd11,
		CMD_RRC = 5'd12,
		CMD_RAL = 5'd13,
		CMD_RAR = 5'd14,
		CMD_CMA = 5'd15,
		CMD_CMC = 5'd16,
		CMD_STC = 5'd17
	} cmd_t;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [DataW-1:0] acc_value;
		logic [DataW-1:0] operand;
		logic [DataW-1:0] flags_in;
	} alu_req_t;

	typedef struct packed {
		logic [DataW-1:0] result;
		logic [DataW-1:0] flags_out;
		logic             write_result;
	} alu_rsp_t;

endpackage

FILE: design/alu8f_core.sv
// ----------------------------------------------------------------------------
// alu8f_core
// Combinational datapath: decodes one request and forms result and flags.
// ----------------------------------------------------------------------------
module alu8f_core (
	input  alu8f_pkg::alu_req_t req,
	output alu8f_pkg::alu_rsp_t rsp
);
	import alu8f_pkg::*;

	logic [DataW-1:0] a;
	logic [DataW-1:0] b;
	logic [DataW-1:0] fin;
	logic             cy;
	logic             ci;
	logic [DataW:0]   add_t;
	logic [DataW:0]   sub_t;
	logic [4:0]       add_n;
	logic [4:0]       sub_n;
	logic             lo_gt9;
	logic             hi_gt99;
	logic [DataW-1:0] daa_cor;
	logic [DataW-1:0] res;
	logic [DataW-1:0] fout;
	logic             wr;
	logic             set_szp;
	logic             ac_v;
	logic             cy_v;
	logic             upd_ac;
	logic             upd_cy;

	assign a   = req.acc_value;
	assign b   = req.operand;
	assign fin = req.flags_in;
	assign cy  = fin[FlagCy];

	// carry / borrow in only for adc and sbb
	assign ci = ((req.cmd == CMD_ADC) || (req.cmd == CMD_SBB)) ? cy : 1'b0;

	assign add_t = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, ci};
	assign sub_t = {1'b0, a} - {1'b0, b} - {{DataW{1'b0}}, ci};
	assign add_n = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
	assign sub_n = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

	assign lo_gt9  = (a[3:0] > 4'd9);
	assign hi_gt99 = (a > 8'h99);
	assign daa_cor = ((lo_gt9 || fin[FlagAc]) ? 8'h06 : 8'h00)
		| ((hi_gt99 || cy) ? 8'h60 : 8'h00);

	always_comb begin
		res     = a;
		wr      = 1'b0;
		set_szp = 1'b0;
		ac_v    = fin[FlagAc];
		cy_v    = cy;
		upd_ac  = 1'b0;
		upd_cy  = 1'b0;
		fout    = fin;
		unique case (req.cmd) inside
			CMD_ADD, CMD_ADC: begin
				res     = add_t[DataW-1:0];
				wr      = 1'b1;
				set_szp = 1'b1;
				ac_v    = add_n[4];
				cy_v    = add_t[DataW];
				upd_ac  = 1'b1;
				upd_cy  = 1'b1;
			end
			CMD_SUB, CMD_SBB, CMD_CMP: begin
				res     = sub_t[DataW-1:0];
				wr      = (req.cmd != CMD_CMP);
				set_szp = 1'b1;
				ac_v    = sub_n[4];
				cy_v    = sub_t[DataW];
				upd_ac  = 1'b1;
				upd_cy  = 1'b1;
			end
			CMD_ANA, CMD_XRA, CMD_ORA: begin
				if (req.cmd == CMD_ANA) begin
					res = a & b;
				end else if (req.cmd == CMD_XRA) begin
					res = a ^ b;
				end else begin
					res = a | b;
				end
				wr      = 1'b1;
				set_szp = 1'b1;
				cy_v    = 1'b0;
				upd_cy  = 1'b1;
			end
			CMD_INR: begin
				res     = b + 8'd1;
				wr      = 1'b1;
				set_szp = 1'b1;
				ac_v    = (b[3:0] == 4'hF);
				upd_ac  = 1'b1;
			end
			CMD_DCR: begin
				res     = b - 8'd1;
				wr      = 1'b1;
				set_szp = 1'b1;
				ac_v    = (b[3:0] == 4'h0);
				upd_ac  = 1'b1;
			end
			CMD_DAA: begin
				res     = a + daa_cor;
				wr      = 1'b1;
				set_szp = 1'b1;
				ac_v    = lo_gt9;
				cy_v    = cy | hi_gt99;
				upd_ac  = 1'b1;
				upd_cy  = 1'b1;
			end
			CMD_RLC: begin
				res    = {a[6:0], a[7]};
				wr     = 1'b1;
				cy_v   = a[7];
				upd_cy = 1'b1;
			end
			CMD_RRC: begin
				res    = {a[0], a[7:1]};
				wr     = 1'b1;
				cy_v   = a[0];
				upd_cy = 1'b1;
			end
			CMD_RAL: begin
				res    = {a[6:0], cy};
				wr     = 1'b1;
				cy_v   = a[7];
				upd_cy = 1'b1;
			end
			CMD_RAR: begin
				res    = {cy, a[7:1]};
				wr     = 1'b1;
				cy_v   = a[0];
				upd_cy = 1'b1;
			end
			CMD_CMA: begin
				res = ~a;
				wr  = 1'b1;
			end
			CMD_CMC: begin
				cy_v   = ~cy;
				upd_cy = 1'b1;
			end
			CMD_STC: begin
				cy_v   = 1'b1;
				upd_cy = 1'b1;
			end
			default: begin
				res = a;
			end
		endcase

		if (set_szp) begin
			fout[FlagS] = res[DataW-1];
			fout[FlagZ] = (res == '0);
			fout[FlagP] = ~^res;
		end
		if (upd_ac) begin
			fout[FlagAc] = ac_v;
		end
		if (upd_cy) begin
			fout[FlagCy] = cy_v;
		end
	end

	assign rsp.result       = res;
	assign rsp.flags_out    = fout;
	assign rsp.write_result = wr;

endmodule

FILE: design/eight_bit_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_top
// Eight-bit accumulator ALU with status flags, two-register pipeline.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    cmd, acc_value, operand, flags_in
//  out      out_valid / out_stall  result, flags_out, write_result
//
//  One request per cycle sustained while out_stall is low; a request passes
//  the input register, then ALU logic into the result register.
//  arst_n clears both stage valid bits; payload registers are not reset.
//  out_stall holds the result register; the input register keeps taking
//  a request while the result stage can move, so in_stall rises only when
//  both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [alu8f_pkg::CmdW-1:0]    cmd,
	input  logic [alu8f_pkg::DataW-1:0]   acc_value,
	input  logic [alu8f_pkg::DataW-1:0]   operand,
	input  logic [alu8f_pkg::DataW-1:0]   flags_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [alu8f_pkg::DataW-1:0]   result,
	output logic [alu8f_pkg::DataW-1:0]   flags_out,
	output logic                          write_result
);
	import alu8f_pkg::*;

	logic     vld_s1;
	logic     vld_s2;
	alu_req_t req_s1;
	alu_rsp_t rsp_s2;
	alu_rsp_t rsp_c;
	logic     load_s1;
	logic     load_s2;

	assign load_s2  = !vld_s2 || !out_stall;
	assign load_s1  = !vld_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1 <= in_valid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			req_s1.cmd       <= cmd;
			req_s1.acc_value <= acc_value;
			req_s1.operand   <= operand;
			req_s1.flags_in  <= flags_in;
		end
		if (load_s2 && vld_s1) begin
			rsp_s2 <= rsp_c;
		end
	end

	alu8f_core u_core (
		.req (req_s1),
		.rsp (rsp_c)
	);

	assign out_valid    = vld_s2;
	assign result       = rsp_s2.result;
	assign flags_out    = rsp_s2.flags_out;
	assign write_result = rsp_s2.write_result;

endmodule

FILE: tb/eight_bit_alu_with_flags_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_top_test
// Self-checking bench for the eight-bit ALU. A short table of corner-case
// commands runs first. Random bursts of requests follow, with random output
// stalls, one long output hold-off and one full drain. Every result is
// checked in order against a table row's result or the in-bench predictor.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_top_test;

	import alu8f_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RAND_ITEMS   = 1600;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [CmdW-1:0] CMD_SPARE_LO = 5'd18;
	localparam logic [CmdW-1:0] CMD_SPARE_HI = 5'd31;

	typedef struct packed {
		logic             known;
		logic [CmdW-1:0]  op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic [DataW-1:0] fl_in;
		logic [DataW-1:0] res;
		logic [DataW-1:0] fl_out;
		logic             wr;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [CmdW-1:0]  cmd;
	logic [DataW-1:0] acc_value;
	logic [DataW-1:0] operand;
	logic [DataW-1:0] flags_in;
	logic             out_valid;
	logic             out_stall;
	logic [DataW-1:0] result;
	logic [DataW-1:0] flags_out;
	logic             write_result;

	// typed result for table rows that carry one
	logic     row_known;
	alu_rsp_t row_rsp;

	alu_rsp_t alu_result_q[$];
	int       mismatch_cnt;
	int       cyc_cnt;
	logic     hold_off_req;

	dir_row_t dir_tab [25] = '{
		'{1'b1, CMD_ADD, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h55, 1'b1},
		'{1'b0, CMD_ADD, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0},
		'{1'b1, CMD_ADC, 8'h7F, 8'h00, 8'h01, 8'h80, 8'h90, 1'b1},
		'{1'b0, CMD_ADC, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b0},
		'{1'b1, CMD_SUB, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h95, 1'b1},
		'{1'b1, CMD_SBB, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h95, 1'b1},
		'{1'b0, CMD_SBB, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 1'b0},
		'{1'b0, CMD_ANA, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0},
		'{1'b1, CMD_XRA, 8'hAA, 8'hAA, 8'h00, 8'h00, 8'h44, 1'b1},
		'{1'b1, CMD_ORA, 8'h00, 8'h80, 8'h00, 8'h80, 8'h80, 1'b1},
		'{1'b1, CMD_CMP, 8'h05, 8'h05, 8'h00, 8'h00, 8'h44, 1'b0},
		'{1'b0, CMD_CMP, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0},
		'{1'b1, CMD_INR, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h55, 1'b1},
		'{1'b1, CMD_DCR, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h94, 1'b1},
		'{1'b1, CMD_DAA, 8'h9A, 8'h00, 8'h00, 8'h00, 8'h55, 1'b1},
		'{1'b0, CMD_DAA, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 1'b0},
		'{1'b1, CMD_RLC, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 1'b1},
		'{1'b1, CMD_RRC, 8'h01, 8'h00, 8'h00, 8'h80, 8'h01, 1'b1},
		'{1'b1, CMD_RAL, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1},
		'{1'b1, CMD_RAR, 8'h01, 8'h00, 8'h01, 8'h80, 8'h01, 1'b1},
		'{1'b1, CMD_CMA, 8'h55, 8'h00, 8'hAA, 8'hAA, 8'hAA, 1'b1},
		'{1'b1, CMD_CMC, 8'h3C, 8'h00, 8'hFF, 8'h3C, 8'hFE, 1'b0},
		'{1'b1, CMD_STC, 8'hC3, 8'h00, 8'h00, 8'hC3, 8'h01, 1'b0},
		'{1'b1, CMD_SPARE_LO, 8'h12, 8'h34, 8'h56, 8'h12, 8'h56, 1'b0},
		'{1'b1, CMD_SPARE_HI, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0}
	};

	eight_bit_alu_with_flags_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.acc_value    (acc_value),
		.operand      (operand),
		.flags_in     (flags_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result       (result),
		.flags_out    (flags_out),
		.write_result (write_result)
	);

	function automatic logic [DataW-1:0] put_szp(logic [DataW-1:0] fl, logic [DataW-1:0] v);
		fl[FlagS] = v[7];
		fl[FlagZ] = (v == '0);
		fl[FlagP] = ~^v;
		return fl;
	endfunction

	function automatic alu_rsp_t alu_eval(logic [CmdW-1:0] op, logic [DataW-1:0] a,
		logic [DataW-1:0] b, logic [DataW-1:0] fl);
		alu_rsp_t         r;
		logic             cy;
		logic             ci;
		logic [8:0]       sum;
		logic [4:0]       nib;
		logic [DataW-1:0] cor;
		r.result       = a;
		r.flags_out    = fl;
		r.write_result = 1'b0;
		cy             = fl[FlagCy];
		case (op) inside
			CMD_ADD, CMD_ADC: begin
				ci  = (op == CMD_ADC) ? cy : 1'b0;
				sum = {1'b0, a} + {1'b0, b} + {8'd0, ci};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
				r.result              = sum[7:0];
				r.flags_out           = put_szp(fl, sum[7:0]);
				r.flags_out[FlagAc]   = nib[4];
				r.flags_out[FlagCy]   = sum[8];
				r.write_result        = 1'b1;
			end
			CMD_SUB, CMD_SBB, CMD_CMP: begin
				ci  = (op == CMD_SBB) ? cy : 1'b0;
				sum = {1'b0, a} - {1'b0, b} - {8'd0, ci};
				nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
				r.result              = sum[7:0];
				r.flags_out           = put_szp(fl, sum[7:0]);
				r.flags_out[FlagAc]   = nib[4];
				r.flags_out[FlagCy]   = sum[8];
				r.write_result        = (op != CMD_CMP);
			end
			CMD_ANA, CMD_XRA, CMD_ORA: begin
				if (op == CMD_ANA)
					r.result = a & b;
				else if (op == CMD_XRA)
					r.result = a ^ b;
				else
					r.result = a | b;
				r.flags_out         = put_szp(fl, r.result);
				r.flags_out[FlagCy] = 1'b0;
				r.write_result      = 1'b1;
			end
			CMD_INR, CMD_DCR: begin
				r.result            = (op == CMD_INR) ? b + 8'd1 : b - 8'd1;
				r.flags_out         = put_szp(fl, r.result);
				r.flags_out[FlagAc] = (op == CMD_INR) ? (b[3:0] == 4'hF) : (b[3:0] == 4'h0);
				r.write_result      = 1'b1;
			end
			CMD_DAA: begin
				cor = '0;
				if (a[3:0] > 4'd9 || fl[FlagAc])
					cor = cor | 8'h06;
				if (a > 8'h99 || cy)
					cor = cor | 8'h60;
				r.result            = a + cor;
				r.flags_out         = put_szp(fl, r.result);
				r.flags_out[FlagAc] = (a[3:0] > 4'd9);
				r.flags_out[FlagCy] = cy | (a > 8'h99);
				r.write_result      = 1'b1;
			end
			CMD_RLC: begin
				r.result            = {a[6:0], a[7]};
				r.flags_out[FlagCy] = a[7];
				r.write_result      = 1'b1;
			end
			CMD_RRC: begin
				r.result            = {a[0], a[7:1]};
				r.flags_out[FlagCy] = a[0];
				r.write_result      = 1'b1;
			end
			CMD_RAL: begin
				r.result            = {a[6:0], cy};
				r.flags_out[FlagCy] = a[7];
				r.write_result      = 1'b1;
			end
			CMD_RAR: begin
				r.result            = {cy, a[7:1]};
				r.flags_out[FlagCy] = a[0];
				r.write_result      = 1'b1;
			end
			CMD_CMA: begin
				r.result       = ~a;
				r.write_result = 1'b1;
			end
			CMD_CMC: r.flags_out[FlagCy] = ~cy;
			CMD_STC: r.flags_out[FlagCy] = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	// corner bytes a quarter of the time
	function automatic logic [DataW-1:0] pick_byte();
		logic [DataW-1:0] v;
		v = DataW'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 7))
				0: v = 8'h00;
				1: v = 8'hFF;
				2: v = 8'h0F;
				3: v = 8'hF0;
				4: v = 8'h99;
				5: v = 8'h9A;
				6: v = 8'h7F;
				default: v = 8'h80;
			endcase
		end
		return v;
	endfunction

	task automatic send_request(input logic [CmdW-1:0] op, input logic [DataW-1:0] a,
		input logic [DataW-1:0] b, input logic [DataW-1:0] fl, input logic known,
		input alu_rsp_t rsp);
		@(negedge clk);
		in_valid  <= 1'b1;
		cmd       <= op;
		acc_value <= a;
		operand   <= b;
		flags_in  <= fl;
		row_known <= known;
		row_rsp   <= rsp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	task automatic send_random();
		logic [CmdW-1:0] op;
		if ($urandom_range(0, 9) == 0)
			op = CmdW'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		else
			op = CmdW'($urandom_range(CMD_ADD, CMD_STC));
		send_request(op, pick_byte(), pick_byte(), DataW'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic check_field(input string what, input logic [DataW-1:0] want,
		input logic [DataW-1:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			$display("%0t ns: %s mismatch, expected %02h actual %02h", $time, what, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever
			#(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		while (cyc_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// result side: stall pattern changes per segment, long hold-off on request
	initial begin : rx_stall
		int seg;
		int mode;
		int n;
		int k;
		out_stall = 1'b0;
		forever begin
			seg  = $urandom_range(16, 160);
			mode = $urandom_range(0, 3);
			for (n = 0; n < seg; n++) begin
				@(negedge clk);
				if (hold_off_req) begin
					out_stall <= 1'b1;
					for (k = 1; k < HOLD_CYCLES; k++)
						@(negedge clk);
					hold_off_req = 1'b0;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= (n % 4 < 2);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		alu_rsp_t want;
		cyc_cnt++;
		if (arst_n) begin
			if (in_valid && !in_stall)
				alu_result_q.push_back(row_known ? row_rsp :
					alu_eval(cmd, acc_value, operand, flags_in));
			if (out_valid && !out_stall) begin
				if (alu_result_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t ns: result with none expected, actual %02h %02h %0b",
						$time, result, flags_out, write_result);
				end else begin
					want = alu_result_q.pop_front();
					check_field("result", want.result, result);
					check_field("flags_out", want.flags_out, flags_out);
					check_field("write_result", {7'b0, want.write_result}, {7'b0, write_result});
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int burst;
		int k;
		logic did_hold;
		logic did_drain;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = '0;
		acc_value    = '0;
		operand      = '0;
		flags_in     = '0;
		row_known    = 1'b0;
		row_rsp      = '0;
		hold_off_req = 1'b0;
		mismatch_cnt = 0;
		cyc_cnt      = 0;
		did_hold     = 1'b0;
		did_drain    = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_request(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].fl_in,
				dir_tab[i].known, '{dir_tab[i].res, dir_tab[i].fl_out, dir_tab[i].wr});
		idle_for(3);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			burst = $urandom_range(1, 32);
			if (!did_hold && sent >= 400) begin
				// back-to-back requests against a held output
				did_hold     = 1'b1;
				hold_off_req = 1'b1;
				burst        = 40;
			end
			for (k = 0; k < burst; k++)
				send_random();
			sent += burst;
			if (!did_drain && sent >= 900) begin
				did_drain = 1'b1;
				@(negedge clk);
				in_valid <= 1'b0;
				wait (alu_result_q.size() == 0);
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 8));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (alu_result_q.size() == 0);
		repeat (8)
			@(posedge clk);
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/alu8f_pkg.sv
design/alu8f_core.sv
design/eight_bit_alu_with_flags_top.sv
tb/eight_bit_alu_with_flags_top_test.sv
